// ===== src/weighted_tree_path_distance_assert.svh =====
// Assertion macros for the weighted tree path distance block
`ifndef WEIGHTED_TREE_PATH_DISTANCE_ASSERT_SVH
`define WEIGHTED_TREE_PATH_DISTANCE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define WTPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define WTPD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WTPD_ASSERT(label, prop, msg)
`define WTPD_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== src/wtpd_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the tree path distance block
package wtpd_pkg;

  localparam int NODE_W  = 16;
  localparam int DIST_W  = 32;
  localparam int DEPTH_W = 16;
  localparam int LEVEL_W = 4;

  localparam int DEF_MAX_NODES   = 65536;
  localparam int DEF_LIFT_LEVELS = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hFFFF;

  typedef enum logic {
    OP_ATTACH = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AT_DEP,
    ST_AT_BASE,
    ST_AT_RD,
    ST_AT_EX,
    ST_Q_DEP,
    ST_Q_ORDER,
    ST_LIFT_RD,
    ST_LIFT_EX,
    ST_Q_MEET,
    ST_CLIMB_RD,
    ST_CLIMB_EX,
    ST_CLIMB_ADDV,
    ST_FIN_CHK,
    ST_FIN_RD,
    ST_FIN_EX,
    ST_FIN_ADDV,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] wsum;
  } anc_entry_t;

  typedef struct packed {
    logic               en;
    logic [NODE_W-1:0]  node;
    logic [LEVEL_W-1:0] level;
    anc_entry_t         data;
  } anc_wr_t;

  typedef struct packed {
    logic               en;
    logic [NODE_W-1:0]  node;
    logic [DEPTH_W-1:0] depth;
  } dep_wr_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [LEVEL_W-1:0] level;
  } rd_req_t;

endpackage

// ===== src/wtpd_store.sv =====
`timescale 1ns / 1ps
// Ancestor table and depth memories, one write port and two read ports each
module wtpd_store import wtpd_pkg::*; #(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
  input  logic               clk,
  input  anc_wr_t            anc_wr,
  input  dep_wr_t            dep_wr,
  input  rd_req_t            rd_req,
  output anc_entry_t         rd_anc_a,
  output anc_entry_t         rd_anc_b,
  output logic [DEPTH_W-1:0] rd_dep_a,
  output logic [DEPTH_W-1:0] rd_dep_b
);

  localparam int NODE_AW   = $clog2(MAX_NODES);
  localparam int LVL_W     = $clog2(LIFT_LEVELS);
  localparam int ANC_DEPTH = 2 ** (NODE_AW + LVL_W);
  localparam int DEP_DEPTH = 2 ** NODE_AW;

  anc_entry_t         anc_mem [ANC_DEPTH];
  logic [DEPTH_W-1:0] dep_mem [DEP_DEPTH];

  logic [NODE_AW+LVL_W-1:0] anc_waddr, anc_raddr_a, anc_raddr_b;

  assign anc_waddr   = {anc_wr.node[NODE_AW-1:0], anc_wr.level[LVL_W-1:0]};
  assign anc_raddr_a = {rd_req.node_a[NODE_AW-1:0], rd_req.level[LVL_W-1:0]};
  assign anc_raddr_b = {rd_req.node_b[NODE_AW-1:0], rd_req.level[LVL_W-1:0]};

  always_ff @(posedge clk) begin
    if (anc_wr.en) begin
      anc_mem[anc_waddr] <= anc_wr.data;
    end
    rd_anc_a <= anc_mem[anc_raddr_a];
    rd_anc_b <= anc_mem[anc_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (dep_wr.en) begin
      dep_mem[dep_wr.node[NODE_AW-1:0]] <= dep_wr.depth;
    end
    rd_dep_a <= dep_mem[rd_req.node_a[NODE_AW-1:0]];
    rd_dep_b <= dep_mem[rd_req.node_b[NODE_AW-1:0]];
  end

endmodule

// ===== src/weighted_tree_path_distance.sv =====
`timescale 1ns / 1ps
// Top level: binary-lifting tree path distance with one shared adder
// Attach: depth read, base write, then a read and execute step per level; a null child is ignored.
// Query: depth read, order, a lift read per gap bit and an execute per set bit, then meet;
//   unless met, a climb per level and a final read and add; one registered read a step.
// Result: done high for one cycle with path_distance; busy until the item is finished.
// Reset (sync, high): a clearing pass zeroes the depth memory with busy high.
// A node whose depth reads zero is unattached; its table entries read as zero.
module weighted_tree_path_distance import wtpd_pkg::*; #(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int LIFT_LEVELS = DEF_LIFT_LEVELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  input  logic [15:0]       edge_weight,
  output logic [DIST_W-1:0] path_distance,
  output logic              done
);

`include "weighted_tree_path_distance_assert.svh"

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int LVL_W   = $clog2(LIFT_LEVELS);
  localparam logic [LVL_W-1:0]   LVL_LAST = LVL_W'(LIFT_LEVELS - 1);
  localparam logic [LVL_W-1:0]   LVL_PRE  = LVL_W'(LIFT_LEVELS - 2);
  localparam logic [NODE_AW-1:0] CLR_LAST = NODE_AW'(MAX_NODES - 1);

  state_t state, state_next;

  logic [NODE_W-1:0]  u, u_next, v, v_next, child, child_next;
  logic [DIST_W-1:0]  acc, acc_next, dist_hold, dist_hold_next;
  logic [DEPTH_W-1:0] gap, gap_next;
  logic [LVL_W-1:0]   lvl, lvl_next;
  logic               stopped, stopped_next;
  logic [NODE_AW-1:0] clr_cnt, clr_cnt_next;

  anc_wr_t            anc_wr;
  dep_wr_t            dep_wr;
  rd_req_t            rd_req;
  anc_entry_t         rd_anc_a, rd_anc_b;
  logic [DEPTH_W-1:0] rd_dep_a, rd_dep_b;

  logic               u_in, v_in, a_ok, b_ok, stop_now, gap_bit, child_ok;
  logic [NODE_W-1:0]  anc_u, anc_v;
  logic [DIST_W-1:0]  rd_dist_u, rd_dist_v, add_b, add_sum;
  logic [DEPTH_W-1:0] du, dv, depth_inc;

  wtpd_store #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_store (
    .clk      (clk),
    .anc_wr   (anc_wr),
    .dep_wr   (dep_wr),
    .rd_req   (rd_req),
    .rd_anc_a (rd_anc_a),
    .rd_anc_b (rd_anc_b),
    .rd_dep_a (rd_dep_a),
    .rd_dep_b (rd_dep_b)
  );

  // read data belongs to the nodes held in u and v since the read cycle
  assign u_in      = 32'(u) < MAX_NODES;
  assign v_in      = 32'(v) < MAX_NODES;
  assign a_ok      = u_in && (rd_dep_a != '0);
  assign b_ok      = v_in && (rd_dep_b != '0);
  assign anc_u     = a_ok ? rd_anc_a.node : '0;
  assign anc_v     = b_ok ? rd_anc_b.node : '0;
  assign rd_dist_u = a_ok ? rd_anc_a.wsum : '0;
  assign rd_dist_v = b_ok ? rd_anc_b.wsum : '0;
  assign du        = u_in ? rd_dep_a : '0;
  assign dv        = v_in ? rd_dep_b : '0;
  assign depth_inc = (du == DEPTH_MAX) ? DEPTH_MAX : du + 16'd1;
  assign stop_now  = stopped || (anc_u == '0);
  assign gap_bit   = gap[lvl];
  assign child_ok  = (node_a != '0) && (32'(node_a) < MAX_NODES);

  // the shared adder
  assign add_b   = (state == ST_CLIMB_ADDV || state == ST_FIN_ADDV) ? dist_hold : rd_dist_u;
  assign add_sum = acc + add_b;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_QUERY) state_next = ST_Q_DEP;
          else if (child_ok)      state_next = ST_AT_DEP;
        end
      end
      ST_AT_DEP:  state_next = ST_AT_BASE;
      ST_AT_BASE: state_next = ST_AT_RD;
      ST_AT_RD:   state_next = ST_AT_EX;
      ST_AT_EX: begin
        state_next = (lvl == LVL_PRE) ? ST_IDLE : ST_AT_RD;
      end
      ST_Q_DEP:   state_next = ST_Q_ORDER;
      ST_Q_ORDER: state_next = ST_LIFT_RD;
      ST_LIFT_RD: begin
        if (gap_bit)               state_next = ST_LIFT_EX;
        else if (lvl == LVL_LAST)  state_next = ST_Q_MEET;
      end
      ST_LIFT_EX: begin
        state_next = (lvl == LVL_LAST) ? ST_Q_MEET : ST_LIFT_RD;
      end
      ST_Q_MEET: begin
        state_next = (u == v) ? ST_REPLY : ST_CLIMB_RD;
      end
      ST_CLIMB_RD: state_next = ST_CLIMB_EX;
      ST_CLIMB_EX: begin
        if (anc_u != anc_v)  state_next = ST_CLIMB_ADDV;
        else if (lvl == '0)  state_next = ST_FIN_CHK;
        else                 state_next = ST_CLIMB_RD;
      end
      ST_CLIMB_ADDV: begin
        state_next = (lvl == '0) ? ST_FIN_CHK : ST_CLIMB_RD;
      end
      ST_FIN_CHK: begin
        state_next = (u != v) ? ST_FIN_RD : ST_REPLY;
      end
      ST_FIN_RD:   state_next = ST_FIN_EX;
      ST_FIN_EX:   state_next = ST_FIN_ADDV;
      ST_FIN_ADDV: state_next = ST_REPLY;
      ST_REPLY:    state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath register updates
  always_comb begin
    u_next         = u;
    v_next         = v;
    child_next     = child;
    acc_next       = acc;
    dist_hold_next = dist_hold;
    gap_next       = gap;
    lvl_next       = lvl;
    stopped_next   = stopped;
    clr_cnt_next   = clr_cnt;
    case (state)
      ST_CLEAR: clr_cnt_next = clr_cnt + 1'b1;
      ST_IDLE: begin
        if (start) begin
          child_next = node_a;
          v_next     = node_b;
          if (opcode == OP_QUERY) begin
            u_next   = node_a;
            acc_next = '0;
          end else begin
            u_next   = node_b;
            acc_next = DIST_W'(edge_weight);
          end
        end
      end
      ST_AT_BASE: begin
        lvl_next     = '0;
        stopped_next = 1'b0;
      end
      ST_AT_EX: begin
        acc_next     = add_sum;
        u_next       = anc_u;
        stopped_next = stop_now;
        if (lvl != LVL_PRE) lvl_next = lvl + 1'b1;
      end
      ST_Q_ORDER: begin
        lvl_next = '0;
        if (dv > du) begin
          u_next   = v;
          v_next   = u;
          gap_next = dv - du;
        end else begin
          gap_next = du - dv;
        end
      end
      ST_LIFT_RD: begin
        if (!gap_bit && lvl != LVL_LAST) lvl_next = lvl + 1'b1;
      end
      ST_LIFT_EX: begin
        acc_next = add_sum;
        u_next   = anc_u;
        if (lvl != LVL_LAST) lvl_next = lvl + 1'b1;
      end
      ST_Q_MEET: lvl_next = LVL_LAST;
      ST_CLIMB_EX: begin
        if (anc_u != anc_v) begin
          acc_next       = add_sum;
          dist_hold_next = rd_dist_v;
          u_next         = anc_u;
          v_next         = anc_v;
        end else if (lvl != '0) begin
          lvl_next = lvl - 1'b1;
        end
      end
      ST_CLIMB_ADDV: begin
        acc_next = add_sum;
        if (lvl != '0) lvl_next = lvl - 1'b1;
      end
      ST_FIN_EX: begin
        acc_next       = add_sum;
        dist_hold_next = rd_dist_v;
      end
      ST_FIN_ADDV: acc_next = add_sum;
      default: ;
    endcase
  end

  // memory requests and handshake outputs
  always_comb begin
    rd_req.node_a = u;
    rd_req.node_b = v;
    rd_req.level  = LEVEL_W'(lvl);

    dep_wr.en    = 1'b0;
    dep_wr.node  = child;
    dep_wr.depth = depth_inc;

    anc_wr.en        = 1'b0;
    anc_wr.node      = child;
    anc_wr.level     = '0;
    anc_wr.data.node = u;
    anc_wr.data.wsum = acc;

    unique case (state)
      ST_CLEAR: begin
        dep_wr.en    = 1'b1;
        dep_wr.node  = NODE_W'(clr_cnt);
        dep_wr.depth = '0;
      end
      ST_AT_BASE: begin
        dep_wr.en = 1'b1;
        anc_wr.en = 1'b1;
      end
      ST_AT_EX: begin
        anc_wr.en    = 1'b1;
        anc_wr.level = LEVEL_W'(lvl) + 1'b1;
        if (stop_now) begin
          anc_wr.data = '0;
        end else begin
          anc_wr.data.node = anc_u;
          anc_wr.data.wsum = add_sum;
        end
      end
      default: ;
    endcase

    busy = (state != ST_IDLE);
    done = (state == ST_REPLY);
  end

  assign path_distance = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    u         <= u_next;
    v         <= v_next;
    child     <= child_next;
    acc       <= acc_next;
    dist_hold <= dist_hold_next;
    gap       <= gap_next;
    lvl       <= lvl_next;
    stopped   <= stopped_next;
  end

  `WTPD_ASSERT_RST(a_reset_clears, rst |=> (state == ST_CLEAR), "reset did not start clearing pass")
  `WTPD_ASSERT(a_query_busy, (start && !busy && opcode == OP_QUERY) |=> busy, "query not taken")
  `WTPD_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
  `WTPD_ASSERT(a_no_null_write, anc_wr.en |-> (anc_wr.node != '0), "table write to null node")
  `WTPD_ASSERT(a_dep_wr_phase, dep_wr.en |-> (state == ST_CLEAR || state == ST_AT_BASE), "stray depth write")

endmodule
